/* hdl/mptl_pkg.sv */
// ============================================================================
// mptl_pkg: shared types and constants for the rod cutting core
// Field widths, register indexes, lookback selects and controller links.
// ============================================================================
`default_nettype none

package mptl_pkg;

  localparam int DEF_MAX_LEN = 1023;

  localparam int PIECE_W   = 10;
  localparam int LEN_W     = 10;
  localparam int OUT_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [OUT_W-1:0] OUT_MAX = 10'd1023;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIECE_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIECE_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIECE_C = 2'd2;

  // which piece length a lookback uses
  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_B = 2'd1,
    SEL_C = 2'd2
  } piece_sel_t;

  typedef struct packed {
    logic       load;     // latch request, seed entry 0
    logic       issue;    // issue one lookback read
    piece_sel_t sel;
    logic       advance;  // move to next table entry
    logic       commit;   // fold last read, write pending entry
  } ctrl_cmd_t;

  typedef struct packed {
    logic direct;  // answer known at load (zero or oversize rod)
    logic last;    // current entry is the requested length
  } ctrl_sts_t;

endpackage

`default_nettype wire

/* hdl/mptl_ctrl.sv */
// ============================================================================
// mptl_ctrl: request sequencer
// Steps each table entry through three lookback reads, then reports.
// ============================================================================
`default_nettype none

module mptl_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  mptl_pkg::ctrl_sts_t sts,
  output mptl_pkg::ctrl_cmd_t cmd,
  output logic                busy,
  output logic                done
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RD_A  = 6'b000010,
    ST_RD_B  = 6'b000100,
    ST_RD_C  = 6'b001000,
    ST_FINAL = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.sel     = mptl_pkg::SEL_A;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = sts.direct ? ST_DONE : ST_RD_A;
        end
      end
      ST_RD_A: begin
        cmd.issue  = 1'b1;
        cmd.sel    = mptl_pkg::SEL_A;
        cmd.commit = 1'b1;
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.issue  = 1'b1;
        cmd.sel    = mptl_pkg::SEL_B;
        state_next = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.issue   = 1'b1;
        cmd.sel     = mptl_pkg::SEL_C;
        cmd.advance = 1'b1;
        state_next  = sts.last ? ST_FINAL : ST_RD_A;
      end
      ST_FINAL: begin
        cmd.commit = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

`default_nettype wire

/* hdl/mptl_dp.sv */
// ============================================================================
// mptl_dp: table datapath
// Piece registers, scratch table memory, lookback fold and result registers.
// ============================================================================
`default_nettype none

module mptl_dp #(
  parameter int MAX_LEN = mptl_pkg::DEF_MAX_LEN
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire  [mptl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [mptl_pkg::PIECE_W-1:0]       cfg_data,
  input  wire  [mptl_pkg::LEN_W-1:0]         rod_length,
  input  mptl_pkg::ctrl_cmd_t                cmd,
  output mptl_pkg::ctrl_sts_t                sts,
  output logic [mptl_pkg::OUT_W-1:0]         max_pieces,
  output logic                               possible
);

  localparam int AW = $clog2(MAX_LEN + 1);
  localparam int LW = (AW > mptl_pkg::PIECE_W) ? AW : mptl_pkg::PIECE_W;

  logic [mptl_pkg::PIECE_W-1:0] piece_a;
  logic [mptl_pkg::PIECE_W-1:0] piece_b;
  logic [mptl_pkg::PIECE_W-1:0] piece_c;

  // entry: {reachable, count}
  logic [AW:0] table_mem [0:MAX_LEN];
  logic [AW:0] mem_q;

  logic [AW-1:0] n_len;
  logic [AW-1:0] idx;
  logic [AW-1:0] widx;
  logic          pend;
  logic          rd_valid;
  logic          fwd;
  logic [AW:0]   wr_hold;
  logic          acc_found;
  logic [AW-1:0] acc_best;

  always_ff @(posedge clk) begin
    if (rst) begin
      piece_a <= mptl_pkg::PIECE_W'(1);
      piece_b <= mptl_pkg::PIECE_W'(1);
      piece_c <= mptl_pkg::PIECE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        mptl_pkg::REG_PIECE_A: piece_a <= cfg_data;
        mptl_pkg::REG_PIECE_B: piece_b <= cfg_data;
        mptl_pkg::REG_PIECE_C: piece_c <= cfg_data;
        default: ;
      endcase
    end
  end

  // request classification
  logic rod_over;
  logic rod_zero;
  assign rod_over   = LW'(rod_length) > LW'(MAX_LEN);
  assign rod_zero   = (rod_length == '0);
  assign sts.direct = rod_over || rod_zero;
  assign sts.last   = (idx == n_len);

  // lookback address
  logic [mptl_pkg::PIECE_W-1:0] piece;
  logic [LW-1:0]                diff;
  logic                         look_ok;
  logic [AW-1:0]                raddr;

  always_comb begin
    case (cmd.sel)
      mptl_pkg::SEL_A: piece = piece_a;
      mptl_pkg::SEL_B: piece = piece_b;
      mptl_pkg::SEL_C: piece = piece_c;
      default:         piece = '0;
    endcase
  end

  assign look_ok = (piece != '0) && (LW'(piece) <= LW'(idx));
  assign diff    = LW'(idx) - LW'(piece);
  assign raddr   = diff[AW-1:0];

  // fold the read that came back this cycle
  logic [AW:0]   rd_data;
  logic          cand_ok;
  logic [AW-1:0] cand;
  logic          fold_found;
  logic [AW-1:0] fold_best;
  logic          do_commit;
  logic [AW:0]   wdata;
  logic [LW-1:0] cnt_w;

  assign rd_data    = fwd ? wr_hold : mem_q;
  assign cand_ok    = rd_valid && rd_data[AW];
  assign cand       = rd_data[AW-1:0] + AW'(1);
  assign fold_found = acc_found || cand_ok;
  assign fold_best  = (cand_ok && (!acc_found || (cand > acc_best))) ? cand : acc_best;
  assign do_commit  = cmd.commit && pend;
  assign wdata      = {fold_found, fold_found ? fold_best : AW'(0)};
  assign cnt_w      = LW'(wdata[AW-1:0]);

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      table_mem[AW'(0)] <= {1'b1, AW'(0)};
    end else if (do_commit) begin
      table_mem[widx] <= wdata;
    end
    mem_q <= table_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      rd_valid  <= 1'b0;
      fwd       <= 1'b0;
      acc_found <= 1'b0;
      acc_best  <= '0;
    end else if (cmd.load) begin
      pend      <= 1'b0;
      rd_valid  <= 1'b0;
      fwd       <= 1'b0;
      acc_found <= 1'b0;
      acc_best  <= '0;
    end else begin
      rd_valid <= cmd.issue && look_ok;
      fwd      <= do_commit && cmd.issue && (raddr == widx);
      if (do_commit) begin
        acc_found <= 1'b0;
        acc_best  <= '0;
      end else begin
        acc_found <= fold_found;
        acc_best  <= fold_best;
      end
      if (cmd.advance) begin
        pend <= 1'b1;
      end else if (do_commit) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_len      <= AW'(rod_length) & {AW{~rod_over}};
      idx        <= AW'(1);
      possible   <= rod_zero;
      max_pieces <= '0;
    end else begin
      if (cmd.advance) begin
        widx <= idx;
        idx  <= idx + AW'(1);
      end
      if (do_commit) begin
        wr_hold    <= wdata;
        possible   <= wdata[AW];
        max_pieces <= (cnt_w > LW'(mptl_pkg::OUT_MAX)) ? mptl_pkg::OUT_MAX
                                                       : cnt_w[mptl_pkg::OUT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/max_pieces_three_lengths_core.sv */
// ============================================================================
// max_pieces_three_lengths_core: largest exact cut of a rod
// Answers the largest number of allowed pieces that sum to a rod length.
// ============================================================================
// Usage:
//   Configuration: write piece lengths through cfg_valid/cfg_index/cfg_data;
//   cfg_ready is always high. Index 0, 1, 2 select piece A, B, C; other
//   indexes are dropped. Write only while busy is low. A piece of 0 is unused.
//   Request: drive rod_length and pulse start while busy is low. busy rises
//   on the next cycle and holds until the result has been shown.
//   Result: done strobes for one cycle with max_pieces and possible valid;
//   the receiver cannot stall, so sample it then. An impossible cut gives
//   possible = 0 and max_pieces = 0.
//   Operation: each request rebuilds the scratch table from entry 1 up to the
//   rod length, three lookback reads per entry through the single read port
//   of the table memory. A rod of length 0 or above MAX_LEN skips the table
//   and goes straight to done; the next request may start the cycle after
//   done.
//   Reset: rst (synchronous) returns to idle and sets all pieces to 1. The
//   table needs no clearing pass; entries are always written before read.
// ============================================================================
`default_nettype none

module max_pieces_three_lengths_core #(
  parameter int MAX_LEN = mptl_pkg::DEF_MAX_LEN
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire  [mptl_pkg::LEN_W-1:0]       rod_length,
  output logic                             done,
  output logic [mptl_pkg::OUT_W-1:0]       max_pieces,
  output logic                             possible,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [mptl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [mptl_pkg::PIECE_W-1:0]     cfg_data
);

  mptl_pkg::ctrl_cmd_t cmd;
  mptl_pkg::ctrl_sts_t sts;
  logic                accept;

  // always take configuration writes; the contract keeps them to idle time
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  mptl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mptl_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rod_length (rod_length),
    .cmd        (cmd),
    .sts        (sts),
    .max_pieces (max_pieces),
    .possible   (possible)
  );

endmodule

`default_nettype wire

/* hdl/mptl_checker.sv */
// ============================================================================
// mptl_props: port-level checks for the rod cutting core
// Request/result sequencing seen at the top-level ports.
// ============================================================================
`default_nettype none

module mptl_props (
  input wire                          clk,
  input wire                          rst,
  input wire                          start,
  input wire                          busy,
  input wire                          done,
  input wire [mptl_pkg::OUT_W-1:0]    max_pieces,
  input wire                          possible
);

  // an accepted request makes the core busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but busy stayed low");

  // a result only comes out of a running request
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  // one result per request: the strobe lasts a single cycle, then idle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe not followed by idle");

  // an impossible cut reports zero pieces
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    (done && !possible) |-> (max_pieces == '0))
    else $error("nonzero count on impossible cut");

endmodule

bind max_pieces_three_lengths_core mptl_props u_mptl_props (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .max_pieces (max_pieces),
  .possible   (possible)
);

`default_nettype wire

/* bench/mptl_checker.sv */
// ============================================================================
// mptl_checker: scoreboard for the rod cutting core
// Tracks the piece lengths, predicts the cut for every accepted request and
// compares each strobed result against the oldest prediction.
// ============================================================================
module mptl_checker #(
  parameter int MAX_LEN = mptl_pkg::DEF_MAX_LEN
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [mptl_pkg::LEN_W-1:0]       rod_length,
  input  logic                             done,
  input  logic [mptl_pkg::OUT_W-1:0]       max_pieces,
  input  logic                             possible,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [mptl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mptl_pkg::PIECE_W-1:0]     cfg_data,
  output int                               fail_count,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [mptl_pkg::OUT_W-1:0] pieces;
    logic                       ok;
  } cut_t;

  cut_t                         expected_cuts[$];
  logic [mptl_pkg::PIECE_W-1:0] len_a = 1;
  logic [mptl_pkg::PIECE_W-1:0] len_b = 1;
  logic [mptl_pkg::PIECE_W-1:0] len_c = 1;
  logic [10:0]                  count_tbl[0:MAX_LEN];
  bit                           reach_tbl[0:MAX_LEN];
  int                           errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Rebuild the count table bottom-up for one rod, then read its answer.
  function automatic cut_t max_cut(input logic [mptl_pkg::LEN_W-1:0] rod);
    cut_t r;
    int   pl[3];
    int   p;
    int   j;
    int   best;
    bit   found;
    r.pieces = '0;
    r.ok     = 1'b0;
    if (int'(rod) > MAX_LEN) return r;
    pl[0] = len_a;
    pl[1] = len_b;
    pl[2] = len_c;
    reach_tbl[0] = 1'b1;
    count_tbl[0] = '0;
    for (int i = 1; i <= int'(rod); i++) begin
      found = 1'b0;
      best  = 0;
      for (int k = 0; k < 3; k++) begin
        p = pl[k];
        // zero length pieces never count
        if (p != 0 && p <= i) begin
          j = i - p;
          if (reach_tbl[j] && (!found || int'(count_tbl[j]) + 1 > best)) begin
            best  = int'(count_tbl[j]) + 1;
            found = 1'b1;
          end
        end
      end
      reach_tbl[i] = found;
      count_tbl[i] = found ? 11'(best) : 11'd0;
    end
    if (!reach_tbl[rod]) return r;
    r.ok     = 1'b1;
    r.pieces = (count_tbl[rod] > 11'(mptl_pkg::OUT_MAX)) ? mptl_pkg::OUT_MAX
                                                         : count_tbl[rod][mptl_pkg::OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cut_t want;
    if (rst) begin
      len_a = 1;
      len_b = 1;
      len_c = 1;
      expected_cuts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mptl_pkg::REG_PIECE_A: len_a = cfg_data;
          mptl_pkg::REG_PIECE_B: len_b = cfg_data;
          mptl_pkg::REG_PIECE_C: len_c = cfg_data;
          default: ;
        endcase
      end
      if (start && busy === 1'b0)
        expected_cuts.push_back(max_cut(rod_length));
      if (done === 1'b1) begin
        if (expected_cuts.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding, max_pieces %0d possible %0b",
                   $time, max_pieces, possible);
        end else begin
          want = expected_cuts.pop_front();
          if (max_pieces !== want.pieces) begin
            errors++;
            $display("%0t: max_pieces mismatch, expected %0d, actual %0d",
                     $time, want.pieces, max_pieces);
          end
          if (possible !== want.ok) begin
            errors++;
            $display("%0t: possible mismatch, expected %0b, actual %0b",
                     $time, want.ok, possible);
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_cuts.size();
  end

endmodule

/* bench/tb.sv */
// ============================================================================
// tb: testbench for the rod cutting core
// Drives rod requests and piece length writes with random pauses; a checker
// beside the core predicts every cut and reports mismatches.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest stretch with no handshake; it must cover a full-length rod plus
  // a sender pause.
  localparam int STALL_LIMIT = 20000;
  localparam logic [mptl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                           clk        = 1'b0;
  logic                           rst        = 1'b1;
  logic                           start      = 1'b0;
  logic [mptl_pkg::LEN_W-1:0]     rod_length = '0;
  logic                           cfg_valid  = 1'b0;
  logic [mptl_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [mptl_pkg::PIECE_W-1:0]   cfg_data   = '0;
  logic                           busy;
  logic                           done;
  logic [mptl_pkg::OUT_W-1:0]     max_pieces;
  logic                           possible;
  logic                           cfg_ready;
  int                             fail_count;
  int                             pending;
  int                             quiet = 0;
  bit                             steady = 1'b0;  // set to suppress sender pauses

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  max_pieces_three_lengths_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .rod_length (rod_length),
    .done       (done),
    .max_pieces (max_pieces),
    .possible   (possible),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mptl_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .rod_length (rod_length),
    .done       (done),
    .max_pieces (max_pieces),
    .possible   (possible),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog: count cycles without any handshake or result.
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet);
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Decide whether the sender takes a break before its next request or write.
  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 12);
  endfunction

  // Mostly small piece lengths so random rods often cut exactly; mix in the
  // unused zero length, the largest length and full-range values.
  function automatic logic [mptl_pkg::PIECE_W-1:0] pick_piece();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return mptl_pkg::PIECE_W'($urandom_range(1023));
      default: return mptl_pkg::PIECE_W'($urandom_range(1, 24));
    endcase
  endfunction

  // Keep most rods short; long rods cost three lookback reads per unit of length.
  function automatic logic [mptl_pkg::LEN_W-1:0] pick_rod();
    int r;
    r = $urandom_range(99);
    if (r < 70) return mptl_pkg::LEN_W'($urandom_range(63));
    if (r < 90) return mptl_pkg::LEN_W'($urandom_range(64, 255));
    return mptl_pkg::LEN_W'($urandom_range(1023));
  endfunction

  // Present one request and hold it until the core takes it. Start stays
  // high across back-to-back requests; it only drops for a pause or a drain.
  task automatic send_rod(input logic [mptl_pkg::LEN_W-1:0] len);
    if (take_break()) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start      <= 1'b1;
    rod_length <= len;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start and hold off until every predicted result has come back.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // Write all three piece lengths, optionally followed by a write to the
  // unused index that the core must drop.
  task automatic write_pieces(input logic [mptl_pkg::PIECE_W-1:0] a, b, c, input bit poke);
    logic [mptl_pkg::CFG_IDX_W-1:0] idx[4];
    logic [mptl_pkg::PIECE_W-1:0]   val[4];
    int                             n;
    idx[0] = mptl_pkg::REG_PIECE_A;
    idx[1] = mptl_pkg::REG_PIECE_B;
    idx[2] = mptl_pkg::REG_PIECE_C;
    idx[3] = REG_UNUSED;
    val[0] = a;
    val[1] = b;
    val[2] = c;
    val[3] = mptl_pkg::PIECE_W'($urandom);
    n = poke ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      if (k > 0 && take_break()) begin
        cfg_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset pieces are all 1: every rod cuts into rod_length pieces,
    // including the largest rod and the zero rod.
    send_rod(10'd0);
    send_rod(10'd1);
    send_rod(10'd2);
    send_rod(10'd1023);
    send_rod(10'd512);
    send_rod(10'd341);
    settle();

    // Pieces 3 and 5 with the third unused; exercise impossible cuts.
    write_pieces(10'd3, 10'd5, 10'd0, 1'b1);
    send_rod(10'd1);
    send_rod(10'd7);
    send_rod(10'd8);
    send_rod(10'd9);
    send_rod(10'd0);
    send_rod(10'd1023);
    settle();

    // Largest piece length everywhere.
    write_pieces(10'd1023, 10'd1023, 10'd1023, 1'b0);
    send_rod(10'd1023);
    send_rod(10'd1022);
    send_rod(10'd0);
    settle();

    // Every piece unused: only the zero rod is possible.
    write_pieces(10'd0, 10'd0, 10'd0, 1'b0);
    send_rod(10'd5);
    send_rod(10'd0);
    settle();

    // Mixed extremes: an odd long rod needs an odd piece.
    write_pieces(10'd2, 10'd1023, 10'd7, 1'b1);
    send_rod(10'd1023);
    send_rod(10'd1);
    send_rod(10'd9);
    send_rod(10'd1000);
    settle();

    // Random phases, each with fresh piece lengths; one phase runs without
    // any sender pause. Drain before each reconfiguration.
    for (int ph = 0; ph < 6; ph++) begin
      steady = (ph == 2);
      write_pieces(pick_piece(), pick_piece(), pick_piece(), $urandom_range(3) == 0);
      repeat (28) send_rod(pick_rod());
      settle();
    end
    steady = 1'b0;

    // Give any stray result a chance to show up.
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
